FILE: src/shce_pkg.sv
package shce_pkg;

   // Sequencer controls shared by the schedule and the round datapath
   typedef struct packed {
      logic load;
      logic step;
   } ctl_type;

   typedef logic [15:0][31:0] block_type;
   typedef logic [7:0][31:0]  hash_type;

   localparam int unsigned Rounds = 64;

   // Fixed padding of a single 40-byte message block
   localparam logic [31:0] PadWord = 32'h8000_0000;
   localparam logic [31:0] MsgBits = 32'd320;

   // Standard initial hash, entry 0 is H0
   localparam hash_type StartHash = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] swap32(input logic [31:0] x);
      swap32 = {x[7:0], x[15:8], x[23:16], x[31:24]};
   endfunction

   function automatic logic [31:0] big_sig0(input logic [31:0] x);
      big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_sig1(input logic [31:0] x);
      big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [31:0] small_sig0(input logic [31:0] x);
      small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sig1(input logic [31:0] x);
      small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   // Round constants
   function automatic logic [31:0] round_k(input logic [5:0] idx);
      logic [31:0] k;
      case (idx)
         6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
         default: k = 32'h0;
      endcase
      round_k = k;
   endfunction

endpackage

FILE: src/sha256_hash_chain_extend_top.sv
// Hash chain extend: each accepted word carries a 64-bit value that is hashed
// with SHA-256 together with the current 256-bit chain (chain bytes, then the
// value's bytes least significant first) and the digest becomes the new chain,
// reported as four 64-bit parts. The chain is zero after reset. For each word,
// the block and the initial hash are loaded at the accepting edge, then 64
// rounds run through a single shared round unit and a final step does the
// hash addition. The input stalls while the rounds and the final step run;
// a new word may be accepted while a result still waits, and its final step
// then holds until the pending result is taken. A new word is only taken
// once the last one has left the final step.
module sha256_hash_chain_extend_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_extend_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_digest_part0,
   output logic [63:0] rsp_digest_part1,
   output logic [63:0] rsp_digest_part2,
   output logic [63:0] rsp_digest_part3
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_ROUND = 3'b010,
      ST_FINAL = 3'b100
   } state_type;

   localparam logic [5:0] LastRound = 6'(shce_pkg::Rounds - 1);

   state_type           state_ff, state_in;
   logic [5:0]          round_ff, round_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [3:0][63:0]    chain_ff, chain_in;
   logic                req_take;
   logic                rsp_take;
   logic                finish;
   shce_pkg::ctl_type   ctl;
   shce_pkg::block_type blk;
   shce_pkg::hash_type  work_state;
   shce_pkg::hash_type  hv;
   logic [31:0]         wt;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;

   // Final step waits for a free output slot
   assign finish = (state_ff == ST_FINAL) && (!rsp_valid_ff || !rsp_stall);

   assign ctl.load = req_take;
   assign ctl.step = (state_ff == ST_ROUND);

   // Padded message block
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         blk[2*k]   = chain_ff[k][63:32];
         blk[2*k+1] = chain_ff[k][31:0];
      end
      blk[8]  = shce_pkg::swap32(req_extend_value[31:0]);
      blk[9]  = shce_pkg::swap32(req_extend_value[63:32]);
      blk[10] = shce_pkg::PadWord;
      blk[11] = 32'h0;
      blk[12] = 32'h0;
      blk[13] = 32'h0;
      blk[14] = 32'h0;
      blk[15] = shce_pkg::MsgBits;
   end

   shce_sched u_sched (
      .clock (clock),
      .ctl   (ctl),
      .blk   (blk),
      .wt    (wt)
   );

   shce_round u_round (
      .clock      (clock),
      .ctl        (ctl),
      .round_idx  (round_ff),
      .wt         (wt),
      .work_state (work_state)
   );

   // Final addition onto the initial hash
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         hv[i] = shce_pkg::StartHash[i] + work_state[i];
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      round_in     = round_ff;
      rsp_valid_in = rsp_valid_ff;
      chain_in     = chain_ff;
      if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_ROUND;
               round_in = 6'd0;
            end
         end
         ST_ROUND: begin
            round_in = round_ff + 6'd1;
            if (round_ff == LastRound) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            if (finish) begin
               for (int k = 0; k < 4; k++) begin
                  chain_in[k] = {hv[2*k], hv[2*k+1]};
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         round_ff     <= 6'd0;
         rsp_valid_ff <= 1'b0;
         chain_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
         chain_ff     <= chain_in;
      end
   end

   // Result is the chain register itself; it only changes in the final step
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_digest_part0 = chain_ff[0];
   assign rsp_digest_part1 = chain_ff[1];
   assign rsp_digest_part2 = chain_ff[2];
   assign rsp_digest_part3 = chain_ff[3];

   // Accepted word starts the rounds from zero
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_ROUND) && (round_ff == 6'd0))
      else $error("rounds did not start after accept");

   // Last round hands over to the final step
   a_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) && (round_ff == LastRound) |=> (state_ff == ST_FINAL))
      else $error("missing final step after last round");

   // A result appears only out of the final step
   a_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_FINAL))
      else $error("result raised outside final step");

   // Chain never moves while a result waits
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(chain_ff))
      else $error("chain overwritten under a pending result");

endmodule

FILE: src/shce_sched.sv
module shce_sched (
   input  logic                clock,
   input  shce_pkg::ctl_type   ctl,
   input  shce_pkg::block_type blk,
   output logic [31:0]         wt
);

   // Sliding window holding W[t] .. W[t+15]
   shce_pkg::block_type w_ff;
   shce_pkg::block_type w_in;
   logic [31:0]         next_word;

   // Expansion word for W[t+16]
   always_comb begin
      next_word = shce_pkg::small_sig1(w_ff[14]) + w_ff[9]
                + shce_pkg::small_sig0(w_ff[1]) + w_ff[0];
   end

   always_comb begin
      w_in = w_ff;
      if (ctl.load) begin
         w_in = blk;
      end else if (ctl.step) begin
         for (int i = 0; i < 15; i++) begin
            w_in[i] = w_ff[i+1];
         end
         w_in[15] = next_word;
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
   end

   assign wt = w_ff[0];

endmodule

FILE: src/shce_round.sv
module shce_round (
   input  logic               clock,
   input  shce_pkg::ctl_type  ctl,
   input  logic [5:0]         round_idx,
   input  logic [31:0]        wt,
   output shce_pkg::hash_type work_state
);

   // Working variables a..h in entries 0..7
   shce_pkg::hash_type s_ff;
   shce_pkg::hash_type s_in;
   logic [31:0]        t1;
   logic [31:0]        t2;
   logic [31:0]        ch;
   logic [31:0]        maj;

   // One compression round
   always_comb begin
      ch  = (s_ff[4] & s_ff[5]) ^ (~s_ff[4] & s_ff[6]);
      maj = (s_ff[0] & s_ff[1]) ^ (s_ff[0] & s_ff[2]) ^ (s_ff[1] & s_ff[2]);
      t1  = s_ff[7] + shce_pkg::big_sig1(s_ff[4]) + ch
          + shce_pkg::round_k(round_idx) + wt;
      t2  = shce_pkg::big_sig0(s_ff[0]) + maj;
   end

   always_comb begin
      s_in = s_ff;
      if (ctl.load) begin
         s_in = shce_pkg::StartHash;
      end else if (ctl.step) begin
         s_in[7] = s_ff[6];
         s_in[6] = s_ff[5];
         s_in[5] = s_ff[4];
         s_in[4] = s_ff[3] + t1;
         s_in[3] = s_ff[2];
         s_in[2] = s_ff[1];
         s_in[1] = s_ff[0];
         s_in[0] = t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      s_ff <= s_in;
   end

   assign work_state = s_ff;

endmodule
